@@ sv/mfdl_pkg.sv @@
package mfdl_pkg;

	// circular store depth, a power of two
	localparam int BUFFER_DEPTH     = 4096;
	localparam int SINE_TABLE_DEPTH = 256;

	localparam int ADDR_W   = $clog2(BUFFER_DEPTH);
	localparam int SINE_W   = $clog2(SINE_TABLE_DEPTH);
	localparam int SAMPLE_W = 24;
	localparam int FRAC_W   = 8;
	localparam int POS_W    = ADDR_W + FRAC_W;
	localparam int DLY_W    = (ADDR_W + 11 > 23) ? ADDR_W + 11 : 23;

	localparam int DLEN_W  = 13;
	localparam int DEPTH_W = 20;
	localparam int STEP_W  = 32;
	localparam int PHASE_W = 32;
	localparam int CFG_W   = 32;

	localparam int MUL_A_W = 25;
	localparam int MUL_B_W = 21;
	localparam int MUL_W   = MUL_A_W + MUL_B_W;

	typedef enum logic [1:0] {
		REG_DELAY_LENGTH = 2'd0,
		REG_MOD_DEPTH    = 2'd1,
		REG_PHASE_STEP   = 2'd2
	} reg_idx_t;

	typedef enum logic {
		MUL_OP_DEPTH  = 1'b0,
		MUL_OP_INTERP = 1'b1
	} mul_op_t;

	typedef logic [SINE_TABLE_DEPTH-1:0][SAMPLE_W-1:0] sine_lut_t;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'd1073741824;
	localparam logic [63:0] Q23_MAX     = 64'd8388607;

	// quarter-wave folded taylor series, evaluated at elaboration
	function automatic sine_lut_t build_sine_lut();
		sine_lut_t   lut;
		logic [63:0] t;
		logic [63:0] u;
		logic [63:0] a;
		logic [63:0] a2;
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] sum;
		logic [63:0] q;
		logic [1:0]  quad;
		for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
			t    = (64'(k) << 32) / SINE_TABLE_DEPTH;
			quad = t[31:30];
			u    = {34'd0, t[29:0]};
			if (quad[0])
				u = ONE_Q30 - u;
			a    = (u * HALF_PI_Q30) >> 30;
			a2   = (a * a) >> 30;
			term = a;
			pos  = a;
			neg  = 64'd0;
			term = ((term * a2) >> 30) / 6;
			neg  = neg + term;
			term = ((term * a2) >> 30) / 20;
			pos  = pos + term;
			term = ((term * a2) >> 30) / 42;
			neg  = neg + term;
			term = ((term * a2) >> 30) / 72;
			pos  = pos + term;
			term = ((term * a2) >> 30) / 110;
			neg  = neg + term;
			sum  = (pos > neg) ? pos - neg : 64'd0;
			q    = (sum + 64'd64) >> 7;
			if (q > Q23_MAX)
				q = Q23_MAX;
			lut[k] = quad[1] ? SAMPLE_W'(64'd0 - q) : q[SAMPLE_W-1:0];
		end
		return lut;
	endfunction

	localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage

@@ sv/mfdl_ram.sv @@
module mfdl_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

endmodule

@@ sv/mfdl_mul.sv @@
module mfdl_mul import mfdl_pkg::*; (
	input  logic                       clk,
	input  logic                       en,
	input  mul_op_t                    op,
	input  logic signed [SAMPLE_W-1:0] sine,
	input  logic [DEPTH_W-1:0]         depth,
	input  logic signed [MUL_A_W-1:0]  diff,
	input  logic [FRAC_W-1:0]          frac,
	output logic signed [MUL_W-1:0]    prod_q
);

	logic signed [MUL_A_W-1:0] a;
	logic signed [MUL_B_W-1:0] b;

	// one signed multiplier shared by the lfo scaling and the interpolation
	always_comb begin
		unique case (op)
			MUL_OP_DEPTH: begin
				a = MUL_A_W'(sine);
				b = $signed({1'b0, depth});
			end
			MUL_OP_INTERP: begin
				a = diff;
				b = $signed({{(MUL_B_W - FRAC_W){1'b0}}, frac});
			end
			default: begin
				a = '0;
				b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en)
			prod_q <= a * b;
	end

endmodule

@@ sv/modulated_fractional_delay_line.sv @@
// lfo modulated fractional delay line
// s_axis carries one q1.23 sample per request, m_axis returns one delayed,
// linearly interpolated q1.23 sample per request, in order.
// cfg_we/cfg_addr/cfg_wdata write delay_length (0), mod_depth (1) and
// phase_step (2); other indexes are ignored. write only while the block is idle.
// each sample is stored in a 4096-entry circular ram on acceptance. a sine lfo,
// scaled by mod_depth, moves the read point around the base delay, clamped to
// 1 .. depth-1 samples.
// sequencing: one sample is in flight at a time, through mul, addr, rd0, rd1,
// diff, mul2 and fin. the result becomes valid as fin is left, and s_axis_tready
// returns at that same edge, so no new sample is taken before the last is done.
// the steps come from the shared multiplier (used for lfo scaling and for
// interpolation) and the single ram read port fetching the two neighboring samples.
// a finished result sits in the output register; the next sample is accepted
// while it waits, and the block only holds at its last step if the previous
// result has still not been taken.
// reset: store reads as zero until written, write pointer and lfo phase zero,
// registers at delay 4096, depth 0, phase step 146087.
module modulated_fractional_delay_line import mfdl_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [23:0]         s_axis_tdata,  // [23:0] sample_in
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [23:0]         m_axis_tdata,  // [23:0] sample_out
	input  logic                cfg_we,
	input  logic [1:0]          cfg_addr,
	input  logic [CFG_W-1:0]    cfg_wdata
);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_MUL  = 8'b0000_0010,
		ST_ADDR = 8'b0000_0100,
		ST_RD0  = 8'b0000_1000,
		ST_RD1  = 8'b0001_0000,
		ST_DIFF = 8'b0010_0000,
		ST_MUL2 = 8'b0100_0000,
		ST_FIN  = 8'b1000_0000
	} state_t;

	localparam logic signed [DLY_W-1:0] DLY_LO  = DLY_W'(256);
	localparam logic signed [DLY_W-1:0] DLY_HI  = DLY_W'((BUFFER_DEPTH - 1) * 256);
	localparam logic [DLY_W-1:0]        BASE_HI = DLY_W'(BUFFER_DEPTH);
	localparam logic [ADDR_W-1:0]       WP_LAST = ADDR_W'(BUFFER_DEPTH - 1);

	state_t                     state_q;
	logic [DLEN_W-1:0]          delay_length_q;
	logic [DEPTH_W-1:0]         mod_depth_q;
	logic [STEP_W-1:0]          phase_step_q;
	logic [PHASE_W-1:0]         phase_q;
	logic [ADDR_W-1:0]          wp_q;
	logic                       wrapped_q;
	logic signed [SAMPLE_W-1:0] sine_q;
	logic [POS_W-1:0]           pos_q;
	logic                       v0_q;
	logic                       v1_q;
	logic signed [SAMPLE_W-1:0] s0_q;
	logic signed [MUL_A_W-1:0]  diff_q;
	logic [SAMPLE_W-1:0]        out_q;
	logic                       out_valid_q;

	logic                       in_acc;
	logic signed [MUL_W-1:0]    prod_q;
	logic [SAMPLE_W-1:0]        rdata_q;
	logic [ADDR_W-1:0]          i0;
	logic [ADDR_W-1:0]          i1;
	logic [ADDR_W-1:0]          raddr;
	logic                       rvalid;
	logic [DLY_W-1:0]           base_ext;
	logic [DLY_W-1:0]           base_c;
	logic [DLY_W-1:0]           base_sh;
	logic signed [22:0]         mod_s;
	logic signed [DLY_W-1:0]    delay_raw;
	logic signed [DLY_W-1:0]    delay_c;
	logic [POS_W-1:0]           pos_d;
	logic signed [SAMPLE_W-1:0] s1;
	logic [SAMPLE_W-1:0]        y;
	logic                       out_free;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;
	assign out_free      = !out_valid_q || m_axis_tready;

	mfdl_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(BUFFER_DEPTH)
	) u_ram (
		.clk    (clk),
		.we     (in_acc),
		.waddr  (wp_q),
		.wdata  (s_axis_tdata),
		.raddr  (raddr),
		.rdata_q(rdata_q)
	);

	mfdl_mul u_mul (
		.clk   (clk),
		.en    ((state_q == ST_MUL) || (state_q == ST_MUL2)),
		.op    ((state_q == ST_MUL2) ? MUL_OP_INTERP : MUL_OP_DEPTH),
		.sine  (sine_q),
		.depth (mod_depth_q),
		.diff  (diff_q),
		.frac  (pos_q[FRAC_W-1:0]),
		.prod_q(prod_q)
	);

	// delay = base*256 + floor(sine*depth/2^23), clamped, then read position
	always_comb begin
		base_ext  = DLY_W'(delay_length_q);
		base_c    = (base_ext > BASE_HI) ? BASE_HI : base_ext;
		base_sh   = base_c << FRAC_W;
		mod_s     = 23'(prod_q >>> 23);
		delay_raw = $signed(base_sh) + DLY_W'(mod_s);
		if (delay_raw > DLY_HI)
			delay_c = DLY_HI;
		else if (delay_raw < DLY_LO)
			delay_c = DLY_LO;
		else
			delay_c = delay_raw;
		pos_d = {wp_q, {FRAC_W{1'b0}}} - POS_W'(delay_c);
	end

	// entries above the write pointer are unwritten until the first wrap
	assign i0     = pos_q[POS_W-1:FRAC_W];
	assign i1     = i0 + ADDR_W'(1);
	assign raddr  = (state_q == ST_RD1) ? i1 : i0;
	assign rvalid = wrapped_q || (raddr <= wp_q);

	assign s1 = v1_q ? $signed(rdata_q) : '0;
	assign y  = s0_q + SAMPLE_W'(prod_q >>> FRAC_W);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			delay_length_q <= DLEN_W'(4096);
			mod_depth_q    <= '0;
			phase_step_q   <= STEP_W'(146087);
			phase_q        <= '0;
			wp_q           <= '0;
			wrapped_q      <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_DELAY_LENGTH: delay_length_q <= cfg_wdata[DLEN_W-1:0];
					REG_MOD_DEPTH:    mod_depth_q    <= cfg_wdata[DEPTH_W-1:0];
					REG_PHASE_STEP:   phase_step_q   <= cfg_wdata[STEP_W-1:0];
					default: ;
				endcase
			end
			if ((state_q == ST_FIN) && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && m_axis_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						phase_q <= phase_q + phase_step_q;
						state_q <= ST_MUL;
					end
				end
				ST_MUL:  state_q <= ST_ADDR;
				ST_ADDR: state_q <= ST_RD0;
				ST_RD0:  state_q <= ST_RD1;
				ST_RD1:  state_q <= ST_DIFF;
				ST_DIFF: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						wp_q        <= wp_q + ADDR_W'(1);
						if (wp_q == WP_LAST)
							wrapped_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc)
			sine_q <= $signed(SINE_LUT[phase_q[PHASE_W-1 -: SINE_W]]);
		if (state_q == ST_ADDR)
			pos_q <= pos_d;
		if (state_q == ST_RD0)
			v0_q <= rvalid;
		if (state_q == ST_RD1) begin
			v1_q <= rvalid;
			s0_q <= v0_q ? $signed(rdata_q) : '0;
		end
		if (state_q == ST_DIFF)
			diff_q <= {s1[SAMPLE_W-1], s1} - {s0_q[SAMPLE_W-1], s0_q};
		if ((state_q == ST_FIN) && out_free)
			out_q <= y;
	end

	a_out_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result appeared without finishing a sample");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_MUL))
		else $error("accepted sample did not start processing");

	a_wp_moves_at_fin: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(wp_q) |-> $past(state_q == ST_FIN))
		else $error("write pointer moved outside the final step");

	a_read_behind_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD0) |-> (pos_q != {wp_q, {FRAC_W{1'b0}}}))
		else $error("read position reached the write position");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) && !out_free |=> !s_axis_tready)
		else $error("accepted while the previous result was blocked");

endmodule
